// ----- rtl/core/scsc_pkg.sv -----
// Shared types and constants for the sector cache tag/control store.
// Used by scsc_front, scsc_back, scsc_rsp_queue and the top level.
package scsc_pkg;

   localparam int ENTRIES      = 64;
   localparam int IDX_W        = $clog2(ENTRIES);
   localparam int SECTOR_W     = 32;
   localparam int SLOT_W       = 6;
   localparam int REQ_W        = 3;
   localparam int PIN_W        = 8;
   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam logic [PIN_W-1:0] PIN_MAX = '1;

   localparam logic [REQ_W-1:0] REQ_GET       = 3'd0;
   localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DIRTY     = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FLUSH     = 3'd3;
   localparam logic [REQ_W-1:0] REQ_FLUSH_INV = 3'd4;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NO_VICTIM = 1'b1;

   typedef enum logic [2:0] {
      OP_GET,
      OP_RELEASE,
      OP_DIRTY,
      OP_FLUSH,
      OP_FLUSH_INV
   } op_type;

   typedef struct packed {
      logic [REQ_W-1:0]    req_type;
      logic [SECTOR_W-1:0] sector;
      logic [SLOT_W-1:0]   slot;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_out;
      logic                hit;
      logic                writeback_valid;
      logic [SECTOR_W-1:0] writeback_sector;
      logic                status;
      logic                last;
   } rsp_item_type;

   typedef struct packed {
      op_type              op;
      logic [SECTOR_W-1:0] sector;
      logic [SLOT_W-1:0]   slot;
   } cmd_type;

endpackage

// ----- rtl/core/scsc_front.sv -----
// Request front end: accepts transactions, decodes the request type and
// queues commands for the back end. Depends on scsc_pkg.
module scsc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  scsc_pkg::req_item_type req_item,
   output logic                  full,
   output logic                  cmd_valid,
   input  logic                  cmd_pop,
   output scsc_pkg::cmd_type      cmd
);

   localparam int PW = scsc_pkg::FIFO_PTR_W;
   localparam int CW = scsc_pkg::FIFO_CNT_W;
   localparam int DEPTH = scsc_pkg::FIFO_DEPTH;

   scsc_pkg::cmd_type cmd_q_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   scsc_pkg::cmd_type dec_cmd;
   logic              dec_keep;
   logic              enq;
   logic              deq;

   // decode; drop unknown request types
   always_comb begin
      dec_cmd.sector = req_item.sector;
      dec_cmd.slot   = req_item.slot;
      dec_cmd.op     = scsc_pkg::OP_GET;
      dec_keep       = 1'b1;
      case (req_item.req_type)
         scsc_pkg::REQ_GET:       dec_cmd.op = scsc_pkg::OP_GET;
         scsc_pkg::REQ_RELEASE:   dec_cmd.op = scsc_pkg::OP_RELEASE;
         scsc_pkg::REQ_DIRTY:     dec_cmd.op = scsc_pkg::OP_DIRTY;
         scsc_pkg::REQ_FLUSH:     dec_cmd.op = scsc_pkg::OP_FLUSH;
         scsc_pkg::REQ_FLUSH_INV: dec_cmd.op = scsc_pkg::OP_FLUSH_INV;
         default:                 dec_keep   = 1'b0;
      endcase
   end

   assign full      = (count_ff == CW'(DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = cmd_q_ff[rd_ptr_ff];
   assign enq       = push && !full && dec_keep;
   assign deq       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(enq) - CW'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         cmd_q_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

endmodule

// ----- rtl/core/scsc_back.sv -----
// Back end: tag and pin memories, state bits, lookup, second-chance victim
// scan, release, mark dirty and flush sequencing. Depends on scsc_pkg.
module scsc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  scsc_pkg::cmd_type       cmd,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output scsc_pkg::rsp_item_type  rsp_item
);

   localparam int NE = scsc_pkg::ENTRIES;
   localparam int IW = scsc_pkg::IDX_W;
   localparam int SW = scsc_pkg::SECTOR_W;
   localparam int PNW = scsc_pkg::PIN_W;
   localparam int SLW = scsc_pkg::SLOT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(NE - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_VICTIM,
      ST_ALLOC,
      ST_RESP,
      ST_REL_WAIT,
      ST_REL_DO,
      ST_FL_READ,
      ST_FL_EVAL
   } state_type;

   logic [SW-1:0]  tag_mem [NE];
   logic [PNW-1:0] pin_mem [NE];

   state_type              state_ff, state_in;
   scsc_pkg::cmd_type       cmd_ff, cmd_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic                   issue_done_ff, issue_done_in;
   logic                   eval_on_ff, eval_on_in;
   logic [IW-1:0]          eval_idx_ff, eval_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   logic                   fu_found_ff, fu_found_in;
   logic [IW-1:0]          fu_idx_ff, fu_idx_in;
   logic [SW-1:0]          fu_tag_ff, fu_tag_in;
   logic [IW-1:0]          vic_idx_ff, vic_idx_in;
   logic [SW-1:0]          vic_tag_ff, vic_tag_in;
   scsc_pkg::rsp_item_type  rsp_ff, rsp_in;
   logic [NE-1:0]          valid_ff, valid_in;
   logic [NE-1:0]          dirty_ff, dirty_in;
   logic [NE-1:0]          ref_ff, ref_in;
   logic [SW-1:0]          tag_rd_ff;
   logic [PNW-1:0]         pin_rd_ff;

   logic                   tag_we;
   logic [IW-1:0]          tag_wa;
   logic [SW-1:0]          tag_wd;
   logic                   pin_we;
   logic [IW-1:0]          pin_wa;
   logic [PNW-1:0]         pin_wd;

   logic                   cmd_slot_ok;
   logic [IW-1:0]          cmd_idx;
   logic                   hit_match;
   logic                   unpinned;
   logic                   fl_emit;
   logic                   fl_last;
   logic                   alloc_wbv;
   scsc_pkg::rsp_item_type  fl_item;

   assign cmd_slot_ok = (32'(cmd.slot) < 32'(NE));
   assign cmd_idx     = IW'(cmd.slot);
   assign hit_match   = valid_ff[eval_idx_ff] && (tag_rd_ff == cmd_ff.sector);
   assign unpinned    = (pin_rd_ff == '0);
   assign fl_emit     = valid_ff[idx_ff] && dirty_ff[idx_ff];
   assign fl_last     = ((valid_ff & dirty_ff & ~(NE'(1) << idx_ff)) == '0);
   assign alloc_wbv   = valid_ff[vic_idx_ff] && dirty_ff[vic_idx_ff];

   always_comb begin
      fl_item.slot_out         = SLW'(idx_ff);
      fl_item.hit              = 1'b0;
      fl_item.writeback_valid  = 1'b1;
      fl_item.writeback_sector = tag_rd_ff;
      fl_item.status           = scsc_pkg::STATUS_OK;
      fl_item.last             = fl_last;
   end

   assign rsp_item = (state_ff == ST_FL_EVAL) ? fl_item : rsp_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      eval_on_in    = 1'b0;
      eval_idx_in   = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      fu_found_in   = fu_found_ff;
      fu_idx_in     = fu_idx_ff;
      fu_tag_in     = fu_tag_ff;
      vic_idx_in    = vic_idx_ff;
      vic_tag_in    = vic_tag_ff;
      rsp_in        = rsp_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      ref_in        = ref_ff;
      tag_we        = 1'b0;
      tag_wa        = vic_idx_ff;
      tag_wd        = cmd_ff.sector;
      pin_we        = 1'b0;
      pin_wa        = vic_idx_ff;
      pin_wd        = PNW'(1);
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               cmd_in        = cmd;
               idx_in        = '0;
               issue_done_in = 1'b0;
               free_found_in = 1'b0;
               fu_found_in   = 1'b0;
               case (cmd.op)
                  scsc_pkg::OP_GET: state_in = ST_LOOKUP;
                  scsc_pkg::OP_RELEASE: begin
                     idx_in   = cmd_idx;
                     state_in = ST_REL_WAIT;
                  end
                  scsc_pkg::OP_DIRTY: begin
                     if (cmd_slot_ok && valid_ff[cmd_idx]) begin
                        dirty_in[cmd_idx] = 1'b1;
                     end
                  end
                  scsc_pkg::OP_FLUSH,
                  scsc_pkg::OP_FLUSH_INV: state_in = ST_FL_READ;
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_LOOKUP,
         ST_VICTIM: begin
            // issue one read per cycle; evaluate the previous read
            if (!issue_done_ff) begin
               if (idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
            eval_on_in = !issue_done_ff;

            if (eval_on_ff && (state_ff == ST_LOOKUP)) begin
               if (hit_match) begin
                  pin_we  = 1'b1;
                  pin_wa  = eval_idx_ff;
                  pin_wd  = (pin_rd_ff == scsc_pkg::PIN_MAX) ? scsc_pkg::PIN_MAX
                                                             : pin_rd_ff + PNW'(1);
                  ref_in[eval_idx_ff]     = 1'b1;
                  rsp_in.slot_out         = SLW'(eval_idx_ff);
                  rsp_in.hit              = 1'b1;
                  rsp_in.writeback_valid  = 1'b0;
                  rsp_in.writeback_sector = '0;
                  rsp_in.status           = scsc_pkg::STATUS_OK;
                  rsp_in.last             = 1'b1;
                  state_in                = ST_RESP;
               end else begin
                  if (!valid_ff[eval_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = eval_idx_ff;
                  end
                  if (eval_idx_ff == LAST_IDX) begin
                     if (free_found_ff || !valid_ff[eval_idx_ff]) begin
                        vic_idx_in = free_found_ff ? free_idx_ff : eval_idx_ff;
                        vic_tag_in = '0;
                        state_in   = ST_ALLOC;
                     end else begin
                        idx_in        = '0;
                        issue_done_in = 1'b0;
                        eval_on_in    = 1'b0;
                        fu_found_in   = 1'b0;
                        state_in      = ST_VICTIM;
                     end
                  end
               end
            end else if (eval_on_ff) begin
               if (unpinned && !fu_found_ff) begin
                  fu_found_in = 1'b1;
                  fu_idx_in   = eval_idx_ff;
                  fu_tag_in   = tag_rd_ff;
               end
               if (unpinned && !ref_ff[eval_idx_ff]) begin
                  vic_idx_in = eval_idx_ff;
                  vic_tag_in = tag_rd_ff;
                  state_in   = ST_ALLOC;
               end else begin
                  if (unpinned) begin
                     ref_in[eval_idx_ff] = 1'b0;
                  end
                  if (eval_idx_ff == LAST_IDX) begin
                     if (fu_found_ff) begin
                        vic_idx_in = fu_idx_ff;
                        vic_tag_in = fu_tag_ff;
                        state_in   = ST_ALLOC;
                     end else if (unpinned) begin
                        vic_idx_in = eval_idx_ff;
                        vic_tag_in = tag_rd_ff;
                        state_in   = ST_ALLOC;
                     end else begin
                        rsp_in.slot_out         = '0;
                        rsp_in.hit              = 1'b0;
                        rsp_in.writeback_valid  = 1'b0;
                        rsp_in.writeback_sector = '0;
                        rsp_in.status           = scsc_pkg::STATUS_NO_VICTIM;
                        rsp_in.last             = 1'b1;
                        state_in                = ST_RESP;
                     end
                  end
               end
            end
         end

         ST_ALLOC: begin
            tag_we                  = 1'b1;
            pin_we                  = 1'b1;
            valid_in[vic_idx_ff]    = 1'b1;
            dirty_in[vic_idx_ff]    = 1'b0;
            ref_in[vic_idx_ff]      = 1'b1;
            rsp_in.slot_out         = SLW'(vic_idx_ff);
            rsp_in.hit              = 1'b0;
            rsp_in.writeback_valid  = alloc_wbv;
            rsp_in.writeback_sector = alloc_wbv ? vic_tag_ff : '0;
            rsp_in.status           = scsc_pkg::STATUS_OK;
            rsp_in.last             = 1'b1;
            state_in                = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_REL_WAIT: state_in = ST_REL_DO;

         ST_REL_DO: begin
            if ((32'(cmd_ff.slot) < 32'(NE)) && valid_ff[idx_ff] && !unpinned) begin
               pin_we = 1'b1;
               pin_wa = idx_ff;
               pin_wd = pin_rd_ff - PNW'(1);
            end
            state_in = ST_IDLE;
         end

         ST_FL_READ: state_in = ST_FL_EVAL;

         ST_FL_EVAL: begin
            if (!(fl_emit && rsp_full)) begin
               if (fl_emit) begin
                  rsp_push         = 1'b1;
                  dirty_in[idx_ff] = 1'b0;
               end
               if (idx_ff == LAST_IDX) begin
                  if (cmd_ff.op == scsc_pkg::OP_FLUSH_INV) begin
                     valid_in = '0;
                     dirty_in = '0;
                     ref_in   = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = ST_FL_READ;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b0;
         eval_on_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         fu_found_ff   <= 1'b0;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         ref_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         eval_on_ff    <= eval_on_in;
         free_found_ff <= free_found_in;
         fu_found_ff   <= fu_found_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         ref_ff        <= ref_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      eval_idx_ff <= eval_idx_in;
      free_idx_ff <= free_idx_in;
      fu_idx_ff   <= fu_idx_in;
      fu_tag_ff   <= fu_tag_in;
      vic_idx_ff  <= vic_idx_in;
      vic_tag_ff  <= vic_tag_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      tag_rd_ff <= tag_mem[idx_ff];
      if (tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
   end

   always_ff @(posedge clock) begin
      pin_rd_ff <= pin_mem[idx_ff];
      if (pin_we) begin
         pin_mem[pin_wa] <= pin_wd;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_alloc_sets_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |=> (valid_ff[$past(vic_idx_ff)] && ref_ff[$past(vic_idx_ff)]))
      else $error("allocated slot not valid and referenced");

   a_no_victim_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && (rsp_item.status == scsc_pkg::STATUS_NO_VICTIM))
      |-> (!rsp_item.hit && !rsp_item.writeback_valid))
      else $error("no-victim result carries hit or writeback");

   a_flush_cleans: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FL_EVAL) && rsp_push) |=> !dirty_ff[$past(idx_ff)])
      else $error("flushed slot still dirty");

endmodule

// ----- rtl/core/scsc_rsp_queue.sv -----
// Result queue between the back end and the result channel.
// Depends on scsc_pkg.
module scsc_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_push,
   input  scsc_pkg::rsp_item_type  in_item,
   output logic                   in_full,
   output logic                   empty,
   input  logic                   pop,
   output scsc_pkg::rsp_item_type  rsp_item
);

   localparam int PW = scsc_pkg::FIFO_PTR_W;
   localparam int CW = scsc_pkg::FIFO_CNT_W;
   localparam int DEPTH = scsc_pkg::FIFO_DEPTH;

   scsc_pkg::rsp_item_type q_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          enq;
   logic          deq;

   assign in_full  = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_item = q_ff[rd_ptr_ff];
   assign enq      = in_push && !in_full;
   assign deq      = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(enq) - CW'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- rtl/core/sector_cache_second_chance.sv -----
// Top level of the 64-slot sector cache tag/control store.
// Depends on scsc_pkg, scsc_front, scsc_back and scsc_rsp_queue.
//
// Request channel: a transaction is taken when push is high and full is low.
// Requests: get sector, release slot, mark dirty, flush, flush and invalidate.
// Unknown request types are dropped at the front end with no result.
// Result channel: the oldest result sits on rsp_item while empty is low and
// is taken when pop is high. A get gives one result; a flush gives one result
// per dirty slot, ascending, with last set on the final one.
// Operation: during a get the back end walks the tag and pin memories one slot
// per cycle over a single read port; a miss with no free slot walks them again
// to pick a victim. A release reads the pin count and then writes it back; mark
// dirty is done in the idle state. A flush reads and then evaluates each slot in
// turn and holds on a dirty slot while the result queue is full. Two-deep queues
// on both sides let requests be taken while results wait.
// Reset: synchronous; all slots invalid, clean and unreferenced.
// Stall: when pop stays low the result queue fills, the back end holds, and
// full rises once the request queue fills; nothing is lost.
module sector_cache_second_chance (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  scsc_pkg::req_item_type  req_item,
   output logic                   full,
   output logic                   empty,
   input  logic                   pop,
   output scsc_pkg::rsp_item_type  rsp_item
);

   logic                   cmd_valid;
   logic                   cmd_pop;
   scsc_pkg::cmd_type       cmd;
   logic                   back_push;
   logic                   back_full;
   scsc_pkg::rsp_item_type  back_item;

   scsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_item  (req_item),
      .full      (full),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   scsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (back_full),
      .rsp_push  (back_push),
      .rsp_item  (back_item)
   );

   scsc_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .in_push  (back_push),
      .in_item  (back_item),
      .in_full  (back_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// ----- sim/tb_sector_cache_second_chance.sv -----
// Testbench for sector_cache_second_chance: drives requests through the push/full queue,
// predicts every result with its own model of the slot store, and checks each popped result.
// Depends on scsc_pkg and the RTL top level sector_cache_second_chance.
module tb_sector_cache_second_chance;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 11;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int IDLE_PCT       = 37;
   localparam int HOLD_CYCLES    = 500;
   localparam int DRAIN_CYCLES   = 300;
   localparam int TOTAL_ITEMS    = 330;
   localparam int POOL_SIZE      = 128;

   localparam int ENTRIES  = scsc_pkg::ENTRIES;
   localparam int SECTOR_W = scsc_pkg::SECTOR_W;
   localparam int SLOT_W   = scsc_pkg::SLOT_W;
   localparam int REQ_W    = scsc_pkg::REQ_W;
   localparam int PIN_W    = scsc_pkg::PIN_W;

   localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNUSED_MID   = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

   class cache_scoreboard;
      logic [SECTOR_W-1:0]    tag_mem [ENTRIES];
      bit                     valid_mem [ENTRIES];
      bit                     dirty_mem [ENTRIES];
      bit                     ref_mem [ENTRIES];
      logic [PIN_W-1:0]       pin_mem [ENTRIES];
      scsc_pkg::rsp_item_type awaited_q [$];
      int                     errors;

      function new();
         errors = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            tag_mem[i] = '0;
         end
         clear_slots();
      endfunction

      function void clear_slots();
         for (int i = 0; i < ENTRIES; i++) begin
            valid_mem[i] = 1'b0;
            dirty_mem[i] = 1'b0;
            ref_mem[i]   = 1'b0;
            pin_mem[i]   = '0;
         end
      endfunction

      function void expect_rsp(int slot, bit hit, bit wb, logic [SECTOR_W-1:0] wb_sector,
                               logic status, bit last);
         scsc_pkg::rsp_item_type r;
         r.slot_out         = SLOT_W'(slot);
         r.hit              = hit;
         r.writeback_valid  = wb;
         r.writeback_sector = wb_sector;
         r.status           = status;
         r.last             = last;
         awaited_q.push_back(r);
      endfunction

      function void flush_dirty();
         int first;
         first = awaited_q.size();
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_mem[i] && dirty_mem[i]) begin
               expect_rsp(i, 1'b0, 1'b1, tag_mem[i], scsc_pkg::STATUS_OK, 1'b0);
               dirty_mem[i] = 1'b0;
            end
         end
         if (awaited_q.size() > first)
            awaited_q[awaited_q.size() - 1].last = 1'b1;
      endfunction

      function void get_sector(logic [SECTOR_W-1:0] sector);
         int                  victim;
         int                  first_unpinned;
         bit                  wb;
         logic [SECTOR_W-1:0] wb_sector;
         victim         = -1;
         first_unpinned = -1;
         wb             = 1'b0;
         wb_sector      = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_mem[i] && tag_mem[i] == sector) begin
               if (pin_mem[i] != scsc_pkg::PIN_MAX)
                  pin_mem[i]++;
               ref_mem[i] = 1'b1;
               expect_rsp(i, 1'b1, 1'b0, '0, scsc_pkg::STATUS_OK, 1'b1);
               return;
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (!valid_mem[i]) begin
               victim = i;
               break;
            end
         end
         if (victim < 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (pin_mem[i] != '0)
                  continue;
               if (first_unpinned < 0)
                  first_unpinned = i;
               if (ref_mem[i]) begin
                  ref_mem[i] = 1'b0;
               end else begin
                  victim = i;
                  break;
               end
            end
            if (victim < 0)
               victim = first_unpinned;
            if (victim < 0) begin
               expect_rsp(0, 1'b0, 1'b0, '0, scsc_pkg::STATUS_NO_VICTIM, 1'b1);
               return;
            end
            if (dirty_mem[victim]) begin
               wb        = 1'b1;
               wb_sector = tag_mem[victim];
            end
         end
         tag_mem[victim]   = sector;
         valid_mem[victim] = 1'b1;
         dirty_mem[victim] = 1'b0;
         ref_mem[victim]   = 1'b1;
         pin_mem[victim]   = PIN_W'(1);
         expect_rsp(victim, 1'b0, wb, wb_sector, scsc_pkg::STATUS_OK, 1'b1);
      endfunction

      function void apply_request(scsc_pkg::req_item_type it);
         case (it.req_type)
            scsc_pkg::REQ_GET: get_sector(it.sector);
            scsc_pkg::REQ_RELEASE: begin
               if (valid_mem[it.slot] && pin_mem[it.slot] != '0)
                  pin_mem[it.slot]--;
            end
            scsc_pkg::REQ_DIRTY: begin
               if (valid_mem[it.slot])
                  dirty_mem[it.slot] = 1'b1;
            end
            scsc_pkg::REQ_FLUSH: flush_dirty();
            scsc_pkg::REQ_FLUSH_INV: begin
               flush_dirty();
               clear_slots();
            end
            default: ;
         endcase
      endfunction

      function void field_check(string name, logic [SECTOR_W-1:0] want, logic [SECTOR_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void match_result(scsc_pkg::rsp_item_type got);
         scsc_pkg::rsp_item_type want;
         if (awaited_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual slot_out %0d sector 0x%0h",
                     $time, got.slot_out, got.writeback_sector);
            errors++;
            return;
         end
         want = awaited_q.pop_front();
         field_check("slot_out", want.slot_out, got.slot_out);
         field_check("hit", want.hit, got.hit);
         field_check("writeback_valid", want.writeback_valid, got.writeback_valid);
         field_check("writeback_sector", want.writeback_sector, got.writeback_sector);
         field_check("status", want.status, got.status);
         field_check("last", want.last, got.last);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   pop = 1'b0;
   scsc_pkg::req_item_type req_item = '0;
   logic                   full;
   logic                   empty;
   scsc_pkg::rsp_item_type rsp_item;

   cache_scoreboard     sb = new();
   int                  items_accepted = 0;
   int                  results_taken = 0;
   int                  stuck_cycles = 0;
   bit                  hold_done = 1'b0;
   logic [SECTOR_W-1:0] sector_pool [POOL_SIZE];

   always #HALF_PERIOD clock = ~clock;

   sector_cache_second_chance DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic send_req(logic [REQ_W-1:0] kind, logic [SECTOR_W-1:0] sector,
                           logic [SLOT_W-1:0] slot);
      scsc_pkg::req_item_type it;
      it.req_type = kind;
      it.sector   = sector;
      it.slot     = slot;
      while (!(items_accepted >= 200 && items_accepted < 280)
             && $urandom_range(99, 0) < IDLE_PCT) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.apply_request(it);
      items_accepted++;
      @(negedge clock);
   endtask

   function automatic logic [SLOT_W-1:0] pick_slot(int live_pct);
      int live [$];
      for (int i = 0; i < ENTRIES; i++) begin
         if (sb.valid_mem[i])
            live.push_back(i);
      end
      if (live.size() != 0 && $urandom_range(99, 0) < live_pct)
         return SLOT_W'(live[$urandom_range(live.size() - 1, 0)]);
      return SLOT_W'($urandom);
   endfunction

   task automatic refresh_pool(int keep);
      for (int i = keep; i < POOL_SIZE; i++) begin
         sector_pool[i] = $urandom;
      end
      sector_pool[POOL_SIZE - 1] = '0;
      sector_pool[POOL_SIZE - 2] = '1;
   endtask

   task automatic run_mixed(int count);
      int pool_n;
      int rel_w;
      int dirty_w;
      int r;
      int done;
      pool_n  = $urandom_range(POOL_SIZE, 8);
      rel_w   = $urandom_range(40, 10);
      dirty_w = $urandom_range(25, 5);
      done    = 0;
      while (done < count) begin
         r = $urandom_range(99, 0);
         done++;
         if (r < rel_w) begin
            send_req(scsc_pkg::REQ_RELEASE, $urandom, pick_slot(85));
         end else if (r < rel_w + dirty_w) begin
            send_req(scsc_pkg::REQ_DIRTY, $urandom, pick_slot(85));
         end else if (r < rel_w + dirty_w + 3) begin
            send_req(scsc_pkg::REQ_FLUSH, $urandom, SLOT_W'($urandom));
         end else if (r < rel_w + dirty_w + 6) begin
            send_req(REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST)), $urandom,
                     SLOT_W'($urandom));
         end else if ($urandom_range(99, 0) < 85) begin
            send_req(scsc_pkg::REQ_GET,
                     sector_pool[POOL_SIZE - 1 - $urandom_range(pool_n - 1, 0)],
                     SLOT_W'($urandom));
         end else begin
            send_req(scsc_pkg::REQ_GET, $urandom, SLOT_W'($urandom));
         end
      end
   endtask

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && results_taken >= 40) begin
            hold_done = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         pop <= (results_taken >= 150 && results_taken < 250)
                || $urandom_range(99, 0) >= IDLE_PCT;
         @(posedge clock);
         if (pop && !empty) begin
            sb.match_result(rsp_item);
            results_taken++;
         end
         @(negedge clock);
      end
   end

   initial begin
      int chunk;
      int offset;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_req(scsc_pkg::REQ_GET, 32'h0000_0000, 6'd0);
      send_req(scsc_pkg::REQ_GET, 32'hFFFF_FFFF, 6'd63);
      send_req(scsc_pkg::REQ_GET, 32'h0000_0000, 6'd63);
      send_req(scsc_pkg::REQ_RELEASE, 32'hFFFF_FFFF, 6'd0);
      send_req(scsc_pkg::REQ_RELEASE, 32'h0000_0000, 6'd0);
      send_req(scsc_pkg::REQ_RELEASE, 32'h0000_0000, 6'd0);
      send_req(scsc_pkg::REQ_DIRTY, 32'h0000_0000, 6'd1);
      send_req(scsc_pkg::REQ_DIRTY, 32'hFFFF_FFFF, 6'd63);
      send_req(scsc_pkg::REQ_RELEASE, 32'h0000_0000, 6'd63);
      send_req(scsc_pkg::REQ_FLUSH, 32'h0000_0000, 6'd0);
      send_req(scsc_pkg::REQ_FLUSH, 32'hFFFF_FFFF, 6'd63);
      send_req(scsc_pkg::REQ_GET, 32'h8000_0000, 6'd0);
      send_req(scsc_pkg::REQ_DIRTY, 32'h0000_0000, 6'd2);
      send_req(scsc_pkg::REQ_DIRTY, 32'h0000_0000, 6'd0);
      send_req(REQ_UNUSED_FIRST, 32'hFFFF_FFFF, 6'd63);
      send_req(REQ_UNUSED_MID, 32'h5555_AAAA, 6'd21);
      send_req(REQ_UNUSED_LAST, 32'h0000_0000, 6'd42);
      send_req(scsc_pkg::REQ_GET, 32'hAAAA_5555, 6'd42);
      send_req(scsc_pkg::REQ_FLUSH_INV, 32'h0000_0000, 6'd0);
      send_req(scsc_pkg::REQ_GET, 32'hFFFF_FFFF, 6'd0);
      send_req(scsc_pkg::REQ_RELEASE, 32'h0000_0000, 6'd0);

      refresh_pool(0);

      // fill every slot, pin them all, then dirty and flush the whole store
      send_req(scsc_pkg::REQ_FLUSH_INV, $urandom, SLOT_W'($urandom));
      repeat (ENTRIES) send_req(scsc_pkg::REQ_GET, $urandom, SLOT_W'($urandom));
      repeat (3) send_req(scsc_pkg::REQ_GET, $urandom, SLOT_W'($urandom));
      offset = $urandom_range(ENTRIES - 1, 0);
      for (int i = 0; i < ENTRIES; i++) begin
         send_req(scsc_pkg::REQ_DIRTY, $urandom, SLOT_W'((i + offset) % ENTRIES));
      end
      send_req(scsc_pkg::REQ_FLUSH, $urandom, SLOT_W'($urandom));
      repeat (24) send_req(scsc_pkg::REQ_DIRTY, $urandom, pick_slot(100));
      repeat (16) send_req(scsc_pkg::REQ_RELEASE, $urandom, pick_slot(100));
      repeat (20) send_req(scsc_pkg::REQ_GET, $urandom, SLOT_W'($urandom));

      while (items_accepted < TOTAL_ITEMS) begin
         chunk = $urandom_range(80, 30);
         if (chunk > TOTAL_ITEMS - items_accepted)
            chunk = TOTAL_ITEMS - items_accepted;
         run_mixed(chunk);
         case ($urandom_range(3, 0))
            0: send_req(scsc_pkg::REQ_FLUSH_INV, $urandom, SLOT_W'($urandom));
            1: send_req(scsc_pkg::REQ_FLUSH, $urandom, SLOT_W'($urandom));
            default: ;
         endcase
         if ($urandom_range(1, 0) != 0)
            refresh_pool(POOL_SIZE / 2);
      end
      push <= 1'b0;

      while (sb.awaited_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
